@@ rtl/packet_delay_impairment_queue_assert.svh @@
// Assertion macros for the packet delay impairment queue
`ifndef PACKET_DELAY_IMPAIRMENT_QUEUE_ASSERT_SVH
`define PACKET_DELAY_IMPAIRMENT_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define PDIQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PDIQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PDIQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PDIQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pdiq_pkg.sv @@
// ----------------------------------------------------------------------------
// pdiq_pkg
// Shared types, constants and commands of the delay impairment queue.
// ----------------------------------------------------------------------------
package pdiq_pkg;
    localparam int QUEUE_SLOTS      = 16;
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REORD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [63:0] now_time_us;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] payload_ref;
        logic [15:0] packet_size;
        logic [15:0] buffer_capacity;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic [15:0] out_payload_ref;
        logic [11:0] ret_size;
        logic [4:0]  queued_count;
    } t_rsp;

    typedef enum logic [3:0] {
        DCMD_NONE  = 4'd0,
        DCMD_LOAD  = 4'd1,  // latch request, clear result
        DCMD_DRAW  = 4'd2,  // advance generator
        DCMD_MUL   = 4'd3,  // delay multiply
        DCMD_DLY   = 4'd4,  // form delay, release time
        DCMD_RMUL  = 4'd5,  // reorder multiply
        DCMD_RSUB  = 4'd6,  // subtract reorder shift
        DCMD_SCAN  = 4'd7,  // visit one slot
        DCMD_STORE = 4'd8,  // write free slot
        DCMD_POP   = 4'd9,  // return best slot
        DCMD_SETST = 4'd10  // set status
    } t_dcmd;

    typedef struct packed {
        t_dcmd      op;
        logic [1:0] status;
        logic       dup_rel; // store uses second delay
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic oversize;
        logic hit;        // last draw below the selected threshold
        logic scan_last;
        logic free_found;
        logic best_found;
        logic best_fits;
        logic full;
        logic loss_en;
        logic reord_en;
        logic dup_en;
    } t_sts;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        a = x ^ (x << 13);
        a = a ^ (a >> 17);
        return a ^ (a << 5);
    endfunction
endpackage

@@ rtl/pdiq_if.sv @@
// ----------------------------------------------------------------------------
// pdiq_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface pdiq_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pdiq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pdiq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pdiq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pdiq_datapath.sv @@
// ----------------------------------------------------------------------------
// pdiq_datapath
// Registers, generator, delay arithmetic and slot store of the queue.
// ----------------------------------------------------------------------------
module pdiq_datapath #(
    parameter int SLOTS     = 16,
    parameter int MAX_BYTES = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  pdiq_pkg::t_req   i_req,
    input  pdiq_pkg::t_cmd   i_cmd,
    input  logic [1:0]       i_thr_sel,
    output pdiq_pkg::t_sts   o_sts,
    output pdiq_pkg::t_rsp   o_rsp
);
    import pdiq_pkg::*;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [23:0] r_base, r_jit;
    logic [31:0] r_loss, r_reord, r_dup, r_rng;
    t_req        r_req;
    logic [63:0] r_rel, r_rel2;
    logic [24:0] r_delay;
    logic [56:0] r_prod;
    logic [30:0] r_m;
    logic [SW-1:0] r_idx, r_free, r_best;
    logic        r_free_ok, r_best_ok;
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0] r_cnt;
    t_rsp        r_rsp;

    logic [63:0] mem_rel [SLOTS];
    logic [31:0] mem_ip  [SLOTS];
    logic [15:0] mem_port[SLOTS];
    logic [15:0] mem_pay [SLOTS];
    logic [11:0] mem_len [SLOTS];

    logic [24:0] lo, hi, span;
    logic [31:0] thr;
    logic [64:0] sum;
    logic [63:0] cur_rel;
    logic        due;
    logic [31:0] rng_nxt;

    always_comb begin
        lo   = (r_base > r_jit) ? {1'b0, r_base - r_jit} : 25'd0;
        hi   = {1'b0, r_base} + {1'b0, r_jit};
        span = hi - lo;
        unique case (i_thr_sel)
            2'd0:    thr = r_loss;
            2'd1:    thr = r_reord;
            default: thr = r_dup;
        endcase
        sum     = {1'b0, r_req.now_time_us} + {40'd0, lo + 25'(r_prod[55:31])};
        cur_rel = mem_rel[r_idx];
        due     = r_valid[r_idx] && (cur_rel <= r_req.now_time_us);
        rng_nxt = xorshift(r_rng);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0; r_jit <= '0; r_loss <= '0; r_reord <= '0; r_dup <= '0;
            r_rng <= 32'd1; r_valid <= '0; r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BASE:   r_base  <= i_cfg_data[23:0];
                    REG_JITTER: r_jit   <= i_cfg_data[23:0];
                    REG_LOSS:   r_loss  <= i_cfg_data;
                    REG_REORD:  r_reord <= i_cfg_data;
                    REG_DUP:    r_dup   <= i_cfg_data;
                    REG_SEED:   r_rng   <= (i_cfg_data != 0) ? i_cfg_data : 32'd1;
                    default: ;
                endcase
            end
            if (i_cmd.op == DCMD_DRAW) begin
                r_rng <= rng_nxt;
            end
            if (i_cmd.op == DCMD_STORE) begin
                r_valid[r_free] <= 1'b1;
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.op == DCMD_POP) begin
                r_valid[r_best] <= 1'b0;
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DCMD_LOAD: begin
                r_req <= i_req;
                r_rsp <= '0;
                r_idx <= '0; r_free_ok <= 1'b0; r_best_ok <= 1'b0;
            end
            DCMD_DRAW: r_m <= rng_nxt[30:0];
            DCMD_MUL:  r_prod <= 57'(span) * 57'(r_m);
            DCMD_DLY: begin
                r_delay <= lo + 25'(r_prod[55:31]);
                r_rel   <= sum[64] ? '1 : sum[63:0];
                r_rel2  <= sum[64] ? '1 : sum[63:0];
                r_idx <= '0; r_free_ok <= 1'b0;
            end
            DCMD_RMUL: r_prod <= 57'(r_delay) * 57'({1'b0, r_m} + 32'h4000_0000);
            DCMD_RSUB: r_rel  <= (64'(r_prod[56:31]) > r_rel) ? '0
                                 : r_rel - 64'(r_prod[56:31]);
            DCMD_SCAN: begin
                if (!r_valid[r_idx] && !r_free_ok) begin
                    r_free <= r_idx; r_free_ok <= 1'b1;
                end
                if (due && (!r_best_ok || cur_rel < mem_rel[r_best])) begin
                    r_best <= r_idx; r_best_ok <= 1'b1;
                end
                r_idx <= r_idx + SW'(1);
            end
            DCMD_STORE: begin
                mem_rel[r_free]  <= i_cmd.dup_rel ? r_rel2 : r_rel;
                mem_ip[r_free]   <= r_req.dest_ip;
                mem_port[r_free] <= r_req.dest_port;
                mem_pay[r_free]  <= r_req.payload_ref;
                mem_len[r_free]  <= r_req.packet_size[11:0];
                r_rsp.queued_count <= 5'(r_cnt + CW'(1));
                r_idx <= '0; r_free_ok <= 1'b0;
            end
            DCMD_POP: begin
                r_rsp.out_ip          <= mem_ip[r_best];
                r_rsp.out_port        <= mem_port[r_best];
                r_rsp.out_payload_ref <= mem_pay[r_best];
                r_rsp.ret_size        <= mem_len[r_best];
                r_rsp.queued_count    <= 5'(r_cnt - CW'(1));
            end
            DCMD_SETST: begin
                r_rsp.status       <= i_cmd.status;
                r_rsp.queued_count <= 5'(r_cnt);
            end
            default: ;
        endcase
    end

    assign o_sts.kind       = r_req.kind;
    assign o_sts.oversize   = r_req.packet_size > 16'(MAX_BYTES);
    assign o_sts.hit        = ({1'b0, r_m} < thr) || thr[31];
    assign o_sts.scan_last  = (32'(r_idx) == SLOTS - 1);
    assign o_sts.free_found = r_free_ok;
    assign o_sts.best_found = r_best_ok;
    assign o_sts.best_fits  = 16'(mem_len[r_best]) <= r_req.buffer_capacity;
    assign o_sts.full       = (32'(r_cnt) >= SLOTS);
    assign o_sts.loss_en    = r_loss != 0;
    assign o_sts.reord_en   = r_reord != 0;
    assign o_sts.dup_en     = r_dup != 0;
    assign o_rsp            = r_rsp;
endmodule

@@ rtl/pdiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdiq_ctrl
// Sequencer that walks one request through draws, scan, store or pop.
// ----------------------------------------------------------------------------
`include "packet_delay_impairment_queue_assert.svh"
module pdiq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pdiq_pkg::t_sts i_sts,
    output pdiq_pkg::t_cmd o_cmd,
    output logic [1:0]     o_thr_sel
);
    import pdiq_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001, S_CHECK = 16'h0002, S_LDRAW = 16'h0004,
        S_LTEST = 16'h0008, S_DDRAW = 16'h0010, S_DMUL  = 16'h0020,
        S_DDLY  = 16'h0040, S_RDRAW = 16'h0080, S_RTEST = 16'h0100,
        S_RMUL  = 16'h0200, S_RSUB  = 16'h0400, S_SCAN  = 16'h0800,
        S_DECIDE= 16'h1000, S_UDRAW = 16'h2000, S_UTEST = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_dup, n_dup;      // second pass stores the copy
    logic   r_draw2, n_draw2;  // reorder second draw pending

    always_comb begin
        n_state = r_state; n_dup = r_dup; n_draw2 = r_draw2;
        o_cmd = '{op: DCMD_NONE, status: ST_OK, dup_rel: 1'b0};
        o_thr_sel = 2'd0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = DCMD_LOAD; n_state = S_CHECK; n_dup = 1'b0;
            end
            S_CHECK: begin
                if (i_sts.kind) n_state = S_SCAN;
                else if (i_sts.oversize) begin
                    o_cmd.op = DCMD_SETST; o_cmd.status = ST_INVALID; n_state = S_OUT;
                end else if (i_sts.loss_en) n_state = S_LDRAW;
                else n_state = S_DDRAW;
            end
            S_LDRAW: begin o_cmd.op = DCMD_DRAW; n_state = S_LTEST; end
            S_LTEST: begin
                o_thr_sel = 2'd0;
                if (i_sts.hit) begin
                    o_cmd.op = DCMD_SETST; n_state = S_OUT;
                end else n_state = S_DDRAW;
            end
            S_DDRAW: begin o_cmd.op = DCMD_DRAW; n_state = S_DMUL; end
            S_DMUL:  begin o_cmd.op = DCMD_MUL;  n_state = S_DDLY; end
            S_DDLY: begin
                o_cmd.op = DCMD_DLY;
                n_state = (!r_dup && i_sts.reord_en) ? S_RDRAW : S_SCAN;
                n_draw2 = 1'b0;
            end
            S_RDRAW: begin o_cmd.op = DCMD_DRAW; n_state = S_RTEST; end
            S_RTEST: begin
                o_thr_sel = 2'd1;
                if (r_draw2) n_state = S_RMUL;
                else if (i_sts.hit) begin n_draw2 = 1'b1; n_state = S_RDRAW; end
                else n_state = S_SCAN;
            end
            S_RMUL: begin o_cmd.op = DCMD_RMUL; n_state = S_RSUB; end
            S_RSUB: begin o_cmd.op = DCMD_RSUB; n_state = S_SCAN; end
            S_SCAN: begin
                o_cmd.op = DCMD_SCAN;
                if (i_sts.scan_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.kind) begin
                    if (i_sts.best_found && i_sts.best_fits) begin
                        o_cmd.op = DCMD_POP; n_state = S_OUT;
                    end else begin
                        o_cmd.op = DCMD_SETST; o_cmd.status = ST_INVALID; n_state = S_OUT;
                    end
                end else if (i_sts.full || !i_sts.free_found) begin
                    // first store fails: full; copy: silently discarded
                    o_cmd.op = DCMD_SETST;
                    o_cmd.status = r_dup ? ST_OK : ST_FULL;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = DCMD_STORE; o_cmd.dup_rel = 1'b0;
                    n_state = (!r_dup && i_sts.dup_en) ? S_UDRAW : S_OUT;
                end
            end
            S_UDRAW: begin o_cmd.op = DCMD_DRAW; n_state = S_UTEST; end
            S_UTEST: begin
                o_thr_sel = 2'd2;
                if (i_sts.hit) begin n_dup = 1'b1; n_state = S_DDRAW; end
                else n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_dup <= 1'b0; r_draw2 <= 1'b0;
        end else begin
            r_state <= n_state; r_dup <= n_dup; r_draw2 <= n_draw2;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `PDIQ_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `PDIQ_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `PDIQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
endmodule

@@ rtl/packet_delay_impairment_queue.sv @@
// ----------------------------------------------------------------------------
// packet_delay_impairment_queue
// Delay, loss, reorder and duplicate scheduler over a small slot queue.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_req sink (kind 0 submit, 1 pop); each
// request yields exactly one response on m_rsp. Registers are written on the
// cfg channel (always ready), by the user only while the block is idle; the
// block itself does not enforce this. One request is in flight at a time.
// A pop passes a check state, a slot scan of one slot per cycle and a decide
// state before its response. A submit adds the random draws (one generator
// step per draw state) and the delay multiplies.
// The response sits in an output register; while the receiver stalls it is
// held and no new request is taken.
// Reset empties the queue, clears the config and loads the generator with one.
// ----------------------------------------------------------------------------
`include "packet_delay_impairment_queue_assert.svh"
module packet_delay_impairment_queue #(
    parameter int QUEUE_SLOTS      = pdiq_pkg::QUEUE_SLOTS,
    parameter int MAX_PACKET_BYTES = pdiq_pkg::MAX_PACKET_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pdiq_cfg_if.sink                      cfg,
    pdiq_stream_if.sink                   s_req,
    pdiq_stream_if.source                 m_rsp
);
    import pdiq_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [1:0] thr_sel;
    logic       cfg_we;
    logic       rsp_err;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    pdiq_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_req.valid), .o_in_ready (s_req.ready),
        .o_out_valid(m_rsp.valid), .i_out_ready(m_rsp.ready),
        .i_sts(sts), .o_cmd(cmd), .o_thr_sel(thr_sel)
    );

    pdiq_datapath #(.SLOTS(QUEUE_SLOTS), .MAX_BYTES(MAX_PACKET_BYTES)) u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_we(cfg_we), .i_cfg_index(cfg.index), .i_cfg_data(cfg.data),
        .i_req(s_req.data), .i_cmd(cmd), .i_thr_sel(thr_sel),
        .o_sts(sts), .o_rsp(m_rsp.data)
    );

    // Response with a non-OK status (invalid or full).
    assign rsp_err = m_rsp.valid && (m_rsp.data.status != ST_OK);

    `PDIQ_ASSERT_IMP(a_cnt, i_clk, i_rst_n, m_rsp.valid, m_rsp.data.queued_count <= 5'(QUEUE_SLOTS))
    `PDIQ_ASSERT_IMP(a_st, i_clk, i_rst_n, m_rsp.valid, m_rsp.data.status <= ST_FULL)
    `PDIQ_ASSERT_IMP(a_sz, i_clk, i_rst_n, rsp_err, m_rsp.data.ret_size == '0)
endmodule
